// ===== rtl/obpl_pkg.sv =====
package obpl_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int COORD_W   = 24;
	localparam int HALF_W    = 23;
	localparam int PRI_W     = 16;
	localparam int REGION_W  = 8;
	localparam int QC_W      = 16;
	localparam int ORI_W     = 64;
	localparam int QP_W      = 32;   // product of two quaternion parts
	localparam int M_W       = 34;   // rotation matrix entry, Q28
	localparam int R_W       = 25;   // point minus centre
	localparam int MR_W      = 59;   // matrix entry times relative coordinate
	localparam int L_W       = 62;   // local coordinate, Q28
	localparam int AREA_W    = 46;
	localparam int PART_W    = 46;
	localparam int VOL_W     = 69;
	localparam int HSHIFT    = 28;

	localparam logic CMD_REGISTER = 1'b0;
	localparam logic CMD_QUERY    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [COORD_W-1:0]  cz;
		logic [HALF_W-1:0]   hx;
		logic [HALF_W-1:0]   hy;
		logic [HALF_W-1:0]   hz;
		logic [ORI_W-1:0]    ori;
		logic [PRI_W-1:0]    pri;
		logic [REGION_W-1:0] region;
	} entry_t;

	typedef struct packed {
		logic [HALF_W-1:0]   hx;
		logic [HALF_W-1:0]   hy;
		logic [HALF_W-1:0]   hz;
		logic [PRI_W-1:0]    pri;
		logic [REGION_W-1:0] region;
	} tag_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic last_issue;
		logic busy;
	} dp_status_t;

endpackage

// ===== rtl/obpl_ctrl.sv =====
module obpl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                cmd,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  obpl_pkg::dp_status_t sts,
	output obpl_pkg::ctrl_cmd_t  ctl
);

	obpl_pkg::state_t st_q, st_d;
	logic             out_valid_q;
	logic             accept;

	assign accept    = in_valid && (st_q == obpl_pkg::ST_IDLE);
	assign in_stall  = (st_q != obpl_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			obpl_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd == obpl_pkg::CMD_QUERY && !sts.empty)
						st_d = obpl_pkg::ST_SCAN;
					else
						st_d = obpl_pkg::ST_DONE;
				end
			end
			obpl_pkg::ST_SCAN: begin
				if (sts.last_issue)
					st_d = obpl_pkg::ST_DRAIN;
			end
			obpl_pkg::ST_DRAIN: begin
				if (!sts.busy)
					st_d = obpl_pkg::ST_DONE;
			end
			obpl_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall)
					st_d = obpl_pkg::ST_IDLE;
			end
			default: st_d = obpl_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		ctl.accept   = accept;
		ctl.issue    = 1'b0;
		ctl.load_out = 1'b0;
		case (st_q)
			obpl_pkg::ST_SCAN: ctl.issue    = 1'b1;
			obpl_pkg::ST_DONE: ctl.load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= obpl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == obpl_pkg::ST_SCAN) |-> !sts.empty)
		else $error("scan on empty table");
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == obpl_pkg::ST_DONE) |-> !sts.busy)
		else $error("result loaded while pipeline busy");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == obpl_pkg::ST_DONE))
		else $error("result shown without finishing");
`endif

endmodule

// ===== rtl/obpl_dpath.sv =====
module obpl_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  obpl_pkg::ctrl_cmd_t                   ctl,
	output obpl_pkg::dp_status_t                  sts,
	input  logic                                  cmd,
	input  logic signed [obpl_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [obpl_pkg::COORD_W-1:0]   coord_y,
	input  logic signed [obpl_pkg::COORD_W-1:0]   coord_z,
	input  logic [obpl_pkg::HALF_W-1:0]           half_x,
	input  logic [obpl_pkg::HALF_W-1:0]           half_y,
	input  logic [obpl_pkg::HALF_W-1:0]           half_z,
	input  logic [obpl_pkg::ORI_W-1:0]            orientation,
	input  logic signed [obpl_pkg::PRI_W-1:0]     priority_req,
	input  logic [obpl_pkg::REGION_W-1:0]         region_id,
	output logic                                  found,
	output logic [obpl_pkg::REGION_W-1:0]         region_out,
	output logic                                  table_full,
	output logic [obpl_pkg::CNT_W-1:0]            territory_count
);

	obpl_pkg::entry_t mem [obpl_pkg::MAX_BOXES];

	logic [obpl_pkg::CNT_W-1:0]          count_q;
	logic [obpl_pkg::IDX_W-1:0]          idx_q;
	logic                                cmd_q, full_q;
	logic signed [obpl_pkg::COORD_W-1:0] px_q, py_q, pz_q;

	// stage 1: table read
	logic             v_s1;
	obpl_pkg::entry_t rd_s1;

	// stage 2: quaternion products, relative vector, area
	logic                             v_s2;
	obpl_pkg::tag_t                   tag_s2;
	logic signed [obpl_pkg::QP_W-1:0] xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2;
	logic signed [obpl_pkg::QP_W-1:0] wx_s2, wy_s2, wz_s2;
	logic signed [obpl_pkg::R_W-1:0]  rx_s2, ry_s2, rz_s2;
	logic [obpl_pkg::AREA_W-1:0]      area_s2;

	// stage 3: matrix entries, volume partial products
	logic                             v_s3;
	obpl_pkg::tag_t                   tag_s3;
	logic signed [obpl_pkg::M_W-1:0]  m00_s3, m01_s3, m02_s3, m10_s3, m11_s3, m12_s3;
	logic signed [obpl_pkg::M_W-1:0]  m20_s3, m21_s3, m22_s3;
	logic signed [obpl_pkg::R_W-1:0]  rx_s3, ry_s3, rz_s3;
	logic [obpl_pkg::PART_W-1:0]      vp1_s3, vp0_s3;

	// stage 4: matrix times vector products, volume
	logic                             v_s4;
	obpl_pkg::tag_t                   tag_s4;
	logic signed [obpl_pkg::MR_W-1:0] p00_s4, p01_s4, p02_s4, p10_s4, p11_s4, p12_s4;
	logic signed [obpl_pkg::MR_W-1:0] p20_s4, p21_s4, p22_s4;
	logic [obpl_pkg::VOL_W-1:0]       vol_s4;

	// stage 5: local coordinates
	logic                             v_s5;
	obpl_pkg::tag_t                   tag_s5;
	logic signed [obpl_pkg::L_W-1:0]  lx_s5, ly_s5, lz_s5;
	logic [obpl_pkg::VOL_W-1:0]       vol_s5;

	// stage 6: containment
	logic                             v_s6, hit_s6;
	logic signed [obpl_pkg::PRI_W-1:0] pri_s6;
	logic [obpl_pkg::REGION_W-1:0]    region_s6;
	logic [obpl_pkg::VOL_W-1:0]       vol_s6;

	// best so far
	logic                              have_q;
	logic signed [obpl_pkg::PRI_W-1:0] best_pri_q;
	logic [obpl_pkg::VOL_W-1:0]        best_vol_q;
	logic [obpl_pkg::REGION_W-1:0]     best_region_q;

	logic found_q;
	logic [obpl_pkg::REGION_W-1:0] region_q;
	logic table_full_q;
	logic [obpl_pkg::CNT_W-1:0] tcount_q;

	logic write_en;
	logic take;

	assign write_en = ctl.accept && (cmd == obpl_pkg::CMD_REGISTER) &&
		(count_q < obpl_pkg::CNT_W'(obpl_pkg::MAX_BOXES));

	assign sts.empty      = (count_q == '0);
	assign sts.last_issue = ((obpl_pkg::CNT_W'(idx_q) + 1'b1) == count_q);
	assign sts.busy       = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (write_en)
			mem[count_q[obpl_pkg::IDX_W-1:0]] <= '{cx: coord_x, cy: coord_y, cz: coord_z,
				hx: half_x, hy: half_y, hz: half_z, ori: orientation,
				pri: priority_req, region: region_id};
		if (ctl.issue)
			rd_s1 <= mem[idx_q];
	end

	// control registers: count, scan index, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			if (write_en)
				count_q <= count_q + 1'b1;
			if (ctl.accept)
				idx_q <= '0;
			else if (ctl.issue)
				idx_q <= idx_q + 1'b1;
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			if (ctl.accept)
				have_q <= 1'b0;
			else if (v_s6 && hit_s6 && take)
				have_q <= 1'b1;
		end
	end

	// latch the item
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= cmd;
			px_q   <= coord_x;
			py_q   <= coord_y;
			pz_q   <= coord_z;
			full_q <= (cmd == obpl_pkg::CMD_REGISTER) && !write_en;
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		logic signed [obpl_pkg::QC_W-1:0] qw, qx, qy, qz;
		qw = rd_s1.ori[63:48];
		qx = rd_s1.ori[47:32];
		qy = rd_s1.ori[31:16];
		qz = rd_s1.ori[15:0];
		tag_s2  <= '{hx: rd_s1.hx, hy: rd_s1.hy, hz: rd_s1.hz,
			pri: rd_s1.pri, region: rd_s1.region};
		xx_s2   <= qx * qx;
		yy_s2   <= qy * qy;
		zz_s2   <= qz * qz;
		xy_s2   <= qx * qy;
		xz_s2   <= qx * qz;
		yz_s2   <= qy * qz;
		wx_s2   <= qw * qx;
		wy_s2   <= qw * qy;
		wz_s2   <= qw * qz;
		rx_s2   <= obpl_pkg::R_W'(px_q) - obpl_pkg::R_W'($signed(rd_s1.cx));
		ry_s2   <= obpl_pkg::R_W'(py_q) - obpl_pkg::R_W'($signed(rd_s1.cy));
		rz_s2   <= obpl_pkg::R_W'(pz_q) - obpl_pkg::R_W'($signed(rd_s1.cz));
		area_s2 <= obpl_pkg::AREA_W'(rd_s1.hx) * obpl_pkg::AREA_W'(rd_s1.hy);
	end

	// stage 3
	always_ff @(posedge clk) begin
		logic signed [obpl_pkg::M_W-1:0] one;
		one = obpl_pkg::M_W'(1) <<< obpl_pkg::HSHIFT;
		tag_s3 <= tag_s2;
		rx_s3  <= rx_s2;
		ry_s3  <= ry_s2;
		rz_s3  <= rz_s2;
		m00_s3 <= one - ((obpl_pkg::M_W'(yy_s2) + obpl_pkg::M_W'(zz_s2)) <<< 1);
		m11_s3 <= one - ((obpl_pkg::M_W'(xx_s2) + obpl_pkg::M_W'(zz_s2)) <<< 1);
		m22_s3 <= one - ((obpl_pkg::M_W'(xx_s2) + obpl_pkg::M_W'(yy_s2)) <<< 1);
		m01_s3 <= (obpl_pkg::M_W'(xy_s2) + obpl_pkg::M_W'(wz_s2)) <<< 1;
		m02_s3 <= (obpl_pkg::M_W'(xz_s2) - obpl_pkg::M_W'(wy_s2)) <<< 1;
		m10_s3 <= (obpl_pkg::M_W'(xy_s2) - obpl_pkg::M_W'(wz_s2)) <<< 1;
		m12_s3 <= (obpl_pkg::M_W'(yz_s2) + obpl_pkg::M_W'(wx_s2)) <<< 1;
		m20_s3 <= (obpl_pkg::M_W'(xz_s2) + obpl_pkg::M_W'(wy_s2)) <<< 1;
		m21_s3 <= (obpl_pkg::M_W'(yz_s2) - obpl_pkg::M_W'(wx_s2)) <<< 1;
		vp1_s3 <= obpl_pkg::PART_W'(area_s2[obpl_pkg::AREA_W-1:obpl_pkg::HALF_W]) *
			obpl_pkg::PART_W'(tag_s2.hz);
		vp0_s3 <= obpl_pkg::PART_W'(area_s2[obpl_pkg::HALF_W-1:0]) *
			obpl_pkg::PART_W'(tag_s2.hz);
	end

	// stage 4
	always_ff @(posedge clk) begin
		tag_s4 <= tag_s3;
		p00_s4 <= obpl_pkg::MR_W'(m00_s3) * obpl_pkg::MR_W'(rx_s3);
		p01_s4 <= obpl_pkg::MR_W'(m01_s3) * obpl_pkg::MR_W'(ry_s3);
		p02_s4 <= obpl_pkg::MR_W'(m02_s3) * obpl_pkg::MR_W'(rz_s3);
		p10_s4 <= obpl_pkg::MR_W'(m10_s3) * obpl_pkg::MR_W'(rx_s3);
		p11_s4 <= obpl_pkg::MR_W'(m11_s3) * obpl_pkg::MR_W'(ry_s3);
		p12_s4 <= obpl_pkg::MR_W'(m12_s3) * obpl_pkg::MR_W'(rz_s3);
		p20_s4 <= obpl_pkg::MR_W'(m20_s3) * obpl_pkg::MR_W'(rx_s3);
		p21_s4 <= obpl_pkg::MR_W'(m21_s3) * obpl_pkg::MR_W'(ry_s3);
		p22_s4 <= obpl_pkg::MR_W'(m22_s3) * obpl_pkg::MR_W'(rz_s3);
		vol_s4 <= (obpl_pkg::VOL_W'(vp1_s3) << obpl_pkg::HALF_W) + obpl_pkg::VOL_W'(vp0_s3);
	end

	// stage 5
	always_ff @(posedge clk) begin
		tag_s5 <= tag_s4;
		vol_s5 <= vol_s4;
		lx_s5  <= obpl_pkg::L_W'(p00_s4) + obpl_pkg::L_W'(p01_s4) + obpl_pkg::L_W'(p02_s4);
		ly_s5  <= obpl_pkg::L_W'(p10_s4) + obpl_pkg::L_W'(p11_s4) + obpl_pkg::L_W'(p12_s4);
		lz_s5  <= obpl_pkg::L_W'(p20_s4) + obpl_pkg::L_W'(p21_s4) + obpl_pkg::L_W'(p22_s4);
	end

	// stage 6: min-inclusive, max-exclusive test on each axis
	always_ff @(posedge clk) begin
		logic signed [obpl_pkg::L_W-1:0] hx, hy, hz;
		hx = $signed(obpl_pkg::L_W'(tag_s5.hx) << obpl_pkg::HSHIFT);
		hy = $signed(obpl_pkg::L_W'(tag_s5.hy) << obpl_pkg::HSHIFT);
		hz = $signed(obpl_pkg::L_W'(tag_s5.hz) << obpl_pkg::HSHIFT);
		hit_s6 <= (lx_s5 >= -hx) && (lx_s5 < hx) &&
			(ly_s5 >= -hy) && (ly_s5 < hy) &&
			(lz_s5 >= -hz) && (lz_s5 < hz);
		pri_s6    <= $signed(tag_s5.pri);
		region_s6 <= tag_s5.region;
		vol_s6    <= vol_s5;
	end

	// priority, then smaller volume, then earlier entry
	assign take = !have_q || (pri_s6 > best_pri_q) ||
		((pri_s6 == best_pri_q) && (vol_s6 < best_vol_q));

	always_ff @(posedge clk) begin
		if (v_s6 && hit_s6 && take) begin
			best_pri_q    <= pri_s6;
			best_vol_q    <= vol_s6;
			best_region_q <= region_s6;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			found_q      <= (cmd_q == obpl_pkg::CMD_QUERY) && have_q;
			region_q     <= ((cmd_q == obpl_pkg::CMD_QUERY) && have_q) ? best_region_q : '0;
			table_full_q <= full_q;
			tcount_q     <= count_q;
		end
	end

	assign found           = found_q;
	assign region_out      = region_q;
	assign table_full      = table_full_q;
	assign territory_count = tcount_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= obpl_pkg::CNT_W'(obpl_pkg::MAX_BOXES))
		else $error("entry count past table size");
	a_full_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && cmd == obpl_pkg::CMD_REGISTER && !write_en) |=> $stable(count_q))
		else $error("count moved on dropped register");
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> (obpl_pkg::CNT_W'(idx_q) < count_q))
		else $error("scan index beyond stored entries");
`endif

endmodule

// ===== rtl/oriented_box_priority_lookup.sv =====
// Register item, or query on an empty table: the controller goes straight to its done state,
// loads the result register and then takes the next beat; a stalled result holds it off.
// Query item: the scan reads one table entry a cycle, for each stored box, into a six-stage
// rotate-and-compare pipeline, waits for it to drain, then loads the result register.
// One item is in work at a time.
// Reset (arst_n low) empties the table; box contents are not cleared.
module oriented_box_priority_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [obpl_pkg::COORD_W-1:0] coord_x,
	input  logic signed [obpl_pkg::COORD_W-1:0] coord_y,
	input  logic signed [obpl_pkg::COORD_W-1:0] coord_z,
	input  logic [obpl_pkg::HALF_W-1:0]         half_x,
	input  logic [obpl_pkg::HALF_W-1:0]         half_y,
	input  logic [obpl_pkg::HALF_W-1:0]         half_z,
	input  logic [obpl_pkg::ORI_W-1:0]          orientation,
	input  logic signed [obpl_pkg::PRI_W-1:0]   priority_req,
	input  logic [obpl_pkg::REGION_W-1:0]       region_id,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic [obpl_pkg::REGION_W-1:0]       region_out,
	output logic                                table_full,
	output logic [obpl_pkg::CNT_W-1:0]          territory_count
);

	obpl_pkg::ctrl_cmd_t  ctl;
	obpl_pkg::dp_status_t sts;

	obpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	obpl_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cmd             (cmd),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.half_x          (half_x),
		.half_y          (half_y),
		.half_z          (half_z),
		.orientation     (orientation),
		.priority_req    (priority_req),
		.region_id       (region_id),
		.found           (found),
		.region_out      (region_out),
		.table_full      (table_full),
		.territory_count (territory_count)
	);

endmodule

// ===== verif/obpl_checker.sv =====
`timescale 1ns / 1ps

module obpl_checker
	import obpl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       cmd,
	input  logic signed [COORD_W-1:0]  coord_x,
	input  logic signed [COORD_W-1:0]  coord_y,
	input  logic signed [COORD_W-1:0]  coord_z,
	input  logic [HALF_W-1:0]          half_x,
	input  logic [HALF_W-1:0]          half_y,
	input  logic [HALF_W-1:0]          half_z,
	input  logic [ORI_W-1:0]           orientation,
	input  logic signed [PRI_W-1:0]    priority_req,
	input  logic [REGION_W-1:0]        region_id,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       found,
	input  logic [REGION_W-1:0]        region_out,
	input  logic                       table_full,
	input  logic [CNT_W-1:0]           territory_count,
	output int                         failures,
	output int                         pending,
	output int                         hits
);

	typedef struct packed {
		logic                found;
		logic [REGION_W-1:0] region;
		logic                full;
		logic [CNT_W-1:0]    count;
	} answer_t;

	// shadow copy of the box table
	logic [COORD_W-1:0]  cx_tab [MAX_BOXES];
	logic [COORD_W-1:0]  cy_tab [MAX_BOXES];
	logic [COORD_W-1:0]  cz_tab [MAX_BOXES];
	logic [HALF_W-1:0]   hx_tab [MAX_BOXES];
	logic [HALF_W-1:0]   hy_tab [MAX_BOXES];
	logic [HALF_W-1:0]   hz_tab [MAX_BOXES];
	logic [ORI_W-1:0]    ori_tab [MAX_BOXES];
	logic [PRI_W-1:0]    pri_tab [MAX_BOXES];
	logic [REGION_W-1:0] reg_tab [MAX_BOXES];
	int                  box_count;
	answer_t             answer_q [$];
	answer_t             want;
	answer_t             got;
	int                  mismatches;

	initial begin
		failures   = 0;
		pending    = 0;
		hits       = 0;
		box_count  = 0;
		mismatches = 0;
	end

	function automatic logic within_half(longint v, logic [HALF_W-1:0] h);
		longint lim;
		lim = longint'({41'd0, h}) <<< HSHIFT;
		return (v >= -lim) && (v < lim);
	endfunction

	// move the point into the local frame of box i and test containment
	function automatic logic box_contains(int i, longint px, longint py, longint pz);
		longint w, x, y, z, rx, ry, rz, m00, m11, m22;
		longint xy, xz, yz, wx, wy, wz, lx, ly, lz;
		w  = longint'($signed(ori_tab[i][63:48]));
		x  = longint'($signed(ori_tab[i][47:32]));
		y  = longint'($signed(ori_tab[i][31:16]));
		z  = longint'($signed(ori_tab[i][15:0]));
		rx = px - longint'($signed(cx_tab[i]));
		ry = py - longint'($signed(cy_tab[i]));
		rz = pz - longint'($signed(cz_tab[i]));
		m00 = (64'sd1 <<< HSHIFT) - 2 * (y * y + z * z);
		m11 = (64'sd1 <<< HSHIFT) - 2 * (x * x + z * z);
		m22 = (64'sd1 <<< HSHIFT) - 2 * (x * x + y * y);
		xy = x * y; xz = x * z; yz = y * z;
		wx = w * x; wy = w * y; wz = w * z;
		lx = m00 * rx + 2 * (xy + wz) * ry + 2 * (xz - wy) * rz;
		ly = 2 * (xy - wz) * rx + m11 * ry + 2 * (yz + wx) * rz;
		lz = 2 * (xz + wy) * rx + 2 * (yz - wx) * ry + m22 * rz;
		return within_half(lx, hx_tab[i]) && within_half(ly, hy_tab[i]) &&
			within_half(lz, hz_tab[i]);
	endfunction

	// pick the winning box: priority, then smaller volume, then earlier entry
	function automatic answer_t lookup_point(longint px, longint py, longint pz);
		answer_t             a;
		logic                have;
		logic signed [PRI_W-1:0] best_pri;
		logic signed [PRI_W-1:0] p;
		logic [VOL_W-1:0]    best_vol;
		logic [VOL_W-1:0]    v;
		logic                take;
		a        = '0;
		have     = 1'b0;
		best_pri = '0;
		best_vol = '0;
		for (int i = 0; i < box_count; i++) begin
			if (box_contains(i, px, py, pz)) begin
				p = $signed(pri_tab[i]);
				v = {46'd0, hx_tab[i]} * {46'd0, hy_tab[i]} * {46'd0, hz_tab[i]};
				if (!have)
					take = 1'b1;
				else if (p != best_pri)
					take = p > best_pri;
				else
					take = v < best_vol;
				if (take) begin
					have     = 1'b1;
					best_pri = p;
					best_vol = v;
					a.region = reg_tab[i];
				end
			end
		end
		a.found = have;
		if (!have)
			a.region = '0;
		return a;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// compare each result beat with the oldest expectation
			if (out_valid && !out_stall) begin
				got = '{found, region_out, table_full, territory_count};
				if (answer_q.size() == 0) begin
					failures++;
					$display("[%0t] extra beat: found=%0d region=%0d full=%0d count=%0d",
						$time, found, region_out, table_full, territory_count);
				end else begin
					want = answer_q.pop_front();
					if (got.found)
						hits++;
					if (got !== want) begin
						failures++;
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] exp found=%0d region=%0d full=%0d count=%0d",
								$time, want.found, want.region, want.full, want.count);
							$display("[%0t] got found=%0d region=%0d full=%0d count=%0d",
								$time, got.found, got.region, got.full, got.count);
						end
					end
				end
			end
			// predict the result of each accepted input beat
			if (in_valid && !in_stall) begin
				want = '0;
				if (cmd == CMD_REGISTER) begin
					if (box_count < MAX_BOXES) begin
						cx_tab[box_count]  = coord_x;
						cy_tab[box_count]  = coord_y;
						cz_tab[box_count]  = coord_z;
						hx_tab[box_count]  = half_x;
						hy_tab[box_count]  = half_y;
						hz_tab[box_count]  = half_z;
						ori_tab[box_count] = orientation;
						pri_tab[box_count] = priority_req;
						reg_tab[box_count] = region_id;
						box_count++;
					end else begin
						want.full = 1'b1;
					end
				end else begin
					want = lookup_point(longint'(coord_x), longint'(coord_y),
						longint'(coord_z));
				end
				want.count = CNT_W'(box_count);
				answer_q = {answer_q, want};
			end
			pending = answer_q.size();
		end
	end

endmodule

// ===== verif/oriented_box_priority_lookup_tb.sv =====
`timescale 1ns / 1ps

module oriented_box_priority_lookup_tb;
	import obpl_pkg::*;

	localparam int RANDOM_ITEMS = 730;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 300;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      cmd;
	logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
	logic [HALF_W-1:0]         half_x, half_y, half_z;
	logic [ORI_W-1:0]          orientation;
	logic signed [PRI_W-1:0]   priority_req;
	logic [REGION_W-1:0]       region_id;
	logic                      out_valid;
	logic                      out_stall;
	logic                      found;
	logic [REGION_W-1:0]       region_out;
	logic                      table_full;
	logic [CNT_W-1:0]          territory_count;

	int failures, pending, hits;
	int send_idle, recv_idle;
	int boxes_sent, queries_sent, cycles;
	bit hold_req;

	oriented_box_priority_lookup uut (.*);
	obpl_checker chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// give up on a hung run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("oriented_box_priority_lookup_tb: FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// offer one beat, idling first at random, and hold it until taken
	task automatic send_beat(input logic c, input logic [COORD_W-1:0] x, y, z,
			input logic [HALF_W-1:0] hx, hy, hz, input logic [ORI_W-1:0] q,
			input logic [PRI_W-1:0] p, input logic [REGION_W-1:0] r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		coord_x      <= x;
		coord_y      <= y;
		coord_z      <= z;
		half_x       <= hx;
		half_y       <= hy;
		half_z       <= hz;
		orientation  <= q;
		priority_req <= p;
		region_id    <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (c == CMD_REGISTER)
			boxes_sent++;
		else
			queries_sent++;
	endtask

	task automatic query_at(input logic [COORD_W-1:0] x, y, z);
		send_beat(CMD_QUERY, x, y, z, HALF_W'($urandom), HALF_W'($urandom),
			HALF_W'($urandom), {$urandom, $urandom}, PRI_W'($urandom),
			REGION_W'($urandom));
	endtask

	function automatic logic [ORI_W-1:0] pick_rotation();
		case ($urandom_range(5))
			0:       return {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
			1:       return {16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
			2:       return {16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
			3:       return {16'sd0, 16'sd0, 16'sd16384, 16'sd0};
			4:       return {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
			default: return {16'sd11585, 16'sd0, -16'sd11585, 16'sd0};
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] near_origin(int span);
		return COORD_W'($urandom_range(2 * span) - span);
	endfunction

	function automatic logic [HALF_W-1:0] box_half();
		if ($urandom_range(2) == 0)
			return HALF_W'(256 << $urandom_range(2));
		return HALF_W'($urandom_range(3000, 64));
	endfunction

	localparam logic [COORD_W-1:0] CMAX = 24'h7FFFFF;
	localparam logic [COORD_W-1:0] CMIN = 24'h800000;
	localparam logic [COORD_W-1:0] C0   = 24'd0;
	localparam logic [HALF_W-1:0]  HMAX = 23'h7FFFFF;
	localparam logic [ORI_W-1:0]   IDENT = {16'sd16384, 48'd0};

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_QUERY;
		coord_x      = '0;
		coord_y      = '0;
		coord_z      = '0;
		half_x       = '0;
		half_y       = '0;
		half_z       = '0;
		orientation  = '0;
		priority_req = '0;
		region_id    = '0;
		hold_req     = 1'b0;
		boxes_sent   = 0;
		queries_sent = 0;
		send_idle    = 16;
		recv_idle    = 59;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, edges, ties, degenerate and extreme boxes
		query_at(CMIN, CMIN, CMIN);
		send_beat(CMD_REGISTER, C0, C0, C0, 23'd256, 23'd256, 23'd256, IDENT,
			16'sd0, 8'd1);
		query_at(-24'sd256, -24'sd256, -24'sd256);
		query_at(24'd256, C0, C0);
		send_beat(CMD_REGISTER, C0, C0, C0, 23'd512, 23'd512, 23'd512, IDENT,
			16'sd0, 8'd2);
		query_at(C0, C0, C0);
		send_beat(CMD_REGISTER, C0, C0, C0, 23'd256, 23'd256, 23'd256, IDENT,
			16'sd0, 8'd3);
		query_at(24'sd10, -24'sd10, C0);
		send_beat(CMD_REGISTER, C0, C0, C0, 23'd1024, 23'd1024, 23'd1024,
			{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 16'sh7FFF, 8'd255);
		query_at(24'd100, 24'd50, C0);
		send_beat(CMD_REGISTER, C0, C0, C0, 23'd0, HMAX, HMAX, IDENT, 16'sh8000, 8'd0);
		query_at(C0, C0, C0);
		send_beat(CMD_REGISTER, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX, '1,
			16'sh8000, 8'hAA);
		query_at(CMAX, CMAX, CMAX);
		query_at(CMIN, CMIN, CMIN);
		send_beat(CMD_REGISTER, CMIN, CMIN, CMIN, HMAX, HMAX, HMAX, '0, 16'sd1, 8'h55);
		query_at(CMIN + 24'd5, CMIN, CMIN);
		query_at(C0, C0, C0);

		// random: mostly queries, boxes and points mostly near the origin, some raw noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 250) begin
				send_idle = 59;
				recv_idle = 16;
			end
			if (n == 500) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (n == 400) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (n == 600)
				hold_req = 1'b1;
			if ($urandom_range(99) < ((boxes_sent < MAX_BOXES) ? 25 : 10)) begin
				if ($urandom_range(7) == 0)
					send_beat(CMD_REGISTER, COORD_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom), HALF_W'($urandom), HALF_W'($urandom),
						HALF_W'($urandom), {$urandom, $urandom}, PRI_W'($urandom),
						REGION_W'($urandom));
				else
					send_beat(CMD_REGISTER, near_origin(4096), near_origin(4096),
						near_origin(4096), box_half(), box_half(), box_half(),
						pick_rotation(), PRI_W'($urandom_range(6) - 3),
						REGION_W'($urandom));
			end else begin
				if ($urandom_range(7) == 0)
					query_at(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
				else
					query_at(near_origin(5000), near_origin(5000), near_origin(5000));
			end
		end
		in_valid <= 1'b0;

		// drain, then let the pipeline settle
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d box registrations and %0d point queries, %0d hit a box",
			boxes_sent, queries_sent, hits);
		$display("table filled, overflow drops seen, long result hold-off and full drain done");
		if (failures == 0 && pending == 0) begin
			$display("oriented_box_priority_lookup_tb: PASS");
		end else begin
			$display("%0d failures, %0d results never arrived", failures, pending);
			$display("oriented_box_priority_lookup_tb: FAIL");
		end
		$finish;
	end

endmodule
